// ===== design/coapb1_pkg.sv =====
// Shared types and constants of the block-wise upload collector.
// Depends on nothing; every design file refers to it by scoped names.
package coapb1_pkg;

  localparam int unsigned BODY_CAPACITY_MAX_DEF = 4096;
  localparam int unsigned CAP_RESET             = 4096;
  localparam logic [2:0]  SZX_RESET             = 3'd6;
  localparam logic [2:0]  SZX_BERT              = 3'd7;
  localparam int unsigned CFG_DATA_W            = 13;

  typedef enum logic [0:0] {
    CFG_IDX_CAPACITY = 1'b0,
    CFG_IDX_SZX      = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_MSG     = 2'd1,
    ST_UNEXP_BLOCK = 2'd2,
    ST_NO_SPACE    = 2'd3
  } status_t;

  typedef struct packed {
    logic        option_present;
    logic [19:0] blk_num;
    logic        more_flag;
    logic [2:0]  size_exponent;
    logic        payload_present;
    logic [15:0] payload_length;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        want_more;
    logic        write_enable;
    logic [31:0] write_offset;
    logic [15:0] write_length;
    logic        use_in_place;
    logic        body_done;
    logic [31:0] body_length;
    logic [19:0] ack_number;
    logic [2:0]  ack_szx;
    logic        ack_more;
  } out_item_t;

  // Transfer state carried from one request to the next
  typedef struct packed {
    logic [31:0] coll_off;
    logic [31:0] body_limit;
    logic [19:0] number;
    logic        more;
    logic [2:0]  szx;
  } xfer_state_t;

  // Register loads produced by the configuration decoder
  typedef struct packed {
    logic        cap_load;
    logic [31:0] cap_value;
    logic        szx_load;
    logic [2:0]  szx_value;
  } cfg_load_t;

endpackage

// ===== design/coapb1_cfg.sv =====
// Configuration write decoder: saturates the capacity and forms state loads.
// Depends on coapb1_pkg.
module coapb1_cfg #(
  parameter int unsigned BODY_CAPACITY_MAX = coapb1_pkg::BODY_CAPACITY_MAX_DEF
) (
  input  logic                              cfg_we,
  input  coapb1_pkg::cfg_idx_t              cfg_index,
  input  logic [coapb1_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output coapb1_pkg::cfg_load_t             load
);

  logic [31:0] cap_raw;

  assign cap_raw = {{(32 - coapb1_pkg::CFG_DATA_W){1'b0}}, cfg_wdata};

  always_comb begin
    load           = '0;
    load.cap_value = (cap_raw > 32'(BODY_CAPACITY_MAX)) ? 32'(BODY_CAPACITY_MAX) : cap_raw;
    load.szx_value = cfg_wdata[2:0];
    if (cfg_we) begin
      unique case (cfg_index)
        coapb1_pkg::CFG_IDX_CAPACITY: load.cap_load = 1'b1;
        coapb1_pkg::CFG_IDX_SZX:      load.szx_load = 1'b1;
        default:                      load.cap_load = 1'b0;
      endcase
    end
  end

endmodule

// ===== design/coapb1_state.sv =====
// Transfer state registers: updated per processed request or by config loads.
// Depends on coapb1_pkg.
module coapb1_state #(
  parameter int unsigned BODY_CAPACITY_MAX = coapb1_pkg::BODY_CAPACITY_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  coapb1_pkg::xfer_state_t nxt,
  input  coapb1_pkg::cfg_load_t   load,
  output coapb1_pkg::xfer_state_t cur
);

  localparam int unsigned CapReset =
    (coapb1_pkg::CAP_RESET > BODY_CAPACITY_MAX) ? BODY_CAPACITY_MAX : coapb1_pkg::CAP_RESET;

  coapb1_pkg::xfer_state_t st_r;
  coapb1_pkg::xfer_state_t st_nxt;

  always_comb begin
    st_nxt = st_r;
    if (upd) begin
      st_nxt = nxt;
    end
    if (load.cap_load) begin
      st_nxt.body_limit = load.cap_value;
    end
    if (load.szx_load) begin
      st_nxt.szx = load.szx_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.coll_off   <= '0;
      st_r.body_limit <= 32'(CapReset);
      st_r.number     <= '0;
      st_r.more       <= 1'b0;
      st_r.szx        <= coapb1_pkg::SZX_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign cur = st_r;

endmodule

// ===== design/coapb1_eval.sv =====
// Single-pass evaluation of one request against the transfer state.
// Depends on coapb1_pkg.
module coapb1_eval (
  input  coapb1_pkg::in_item_t    item,
  input  coapb1_pkg::xfer_state_t cur,
  output coapb1_pkg::out_item_t   res,
  output coapb1_pkg::xfer_state_t nxt
);

  logic        bert;
  logic [10:0] blk_size;
  logic [3:0]  shamt;
  logic        size_bad;
  logic [31:0] blk_off;
  logic [31:0] coll0;
  logic [31:0] total;
  logic [2:0]  szx_eff;
  logic        second_blk;

  assign bert     = (item.size_exponent == coapb1_pkg::SZX_BERT);
  assign blk_size = bert ? 11'd1024 : (11'd16 << item.size_exponent);
  assign shamt    = bert ? 4'd10 : ({1'b0, item.size_exponent} + 4'd4);
  assign size_bad = bert ? (item.more_flag && (item.payload_length[9:0] != 10'd0))
                         : ((item.more_flag && (item.payload_length != {5'd0, blk_size}))
                            || (item.payload_length > {5'd0, blk_size}));
  assign blk_off  = {12'd0, item.blk_num} << shamt;
  // Block zero restarts the transfer
  assign coll0    = (item.blk_num == 20'd0) ? 32'd0 : cur.coll_off;
  assign total    = coll0 + {16'd0, item.payload_length};
  assign second_blk = (coll0 != 32'd0) && (cur.number == 20'd0);
  assign szx_eff  = second_blk ? item.size_exponent : cur.szx;

  always_comb begin
    res        = '0;
    res.status = coapb1_pkg::ST_OK;
    nxt        = cur;
    if (!item.payload_present || !item.option_present) begin
      if (cur.coll_off != 32'd0) begin
        res.status = coapb1_pkg::ST_BAD_MSG;
      end else begin
        nxt.number    = '0;
        nxt.more      = 1'b0;
        res.body_done = 1'b1;
        // Length without a payload: body taken as empty
        if (item.payload_present || (item.payload_length == 16'd0)) begin
          if (cur.body_limit != 32'd0) begin
            res.use_in_place = 1'b1;
            nxt.body_limit   = {16'd0, item.payload_length};
          end
          nxt.coll_off    = {16'd0, item.payload_length};
          res.body_length = {16'd0, item.payload_length};
        end
      end
    end else if (size_bad) begin
      res.status = coapb1_pkg::ST_BAD_MSG;
    end else begin
      nxt.coll_off = coll0;
      if (coll0 != blk_off) begin
        res.status = coapb1_pkg::ST_UNEXP_BLOCK;
      end else if (second_blk && (item.size_exponent > cur.szx)) begin
        res.status = coapb1_pkg::ST_BAD_MSG;
      end else if ((coll0 != 32'd0) && (cur.number != 20'd0)
                   && (item.size_exponent != cur.szx)) begin
        res.status = coapb1_pkg::ST_BAD_MSG;
      end else begin
        // A size adopted on the second block stays even on no space
        nxt.szx = szx_eff;
        if (cur.body_limit != 32'd0) begin
          if (!item.more_flag && (coll0 == 32'd0)) begin
            res.use_in_place = 1'b1;
          end else if (total > cur.body_limit) begin
            res.status = coapb1_pkg::ST_NO_SPACE;
          end else begin
            res.write_enable = 1'b1;
            res.write_offset = coll0;
            res.write_length = item.payload_length;
          end
          if ((res.status == coapb1_pkg::ST_OK) && !item.more_flag) begin
            nxt.body_limit = total;
          end
        end
        if (res.status == coapb1_pkg::ST_OK) begin
          nxt.coll_off   = total;
          nxt.number     = item.blk_num;
          nxt.more       = item.more_flag;
          res.want_more  = item.more_flag;
          res.ack_number = item.blk_num;
          res.ack_szx    = szx_eff;
          res.ack_more   = item.more_flag;
          if (!item.more_flag) begin
            res.body_done   = 1'b1;
            res.body_length = total;
          end
        end
      end
    end
  end

endmodule

// ===== design/coap_block1_collector_unit.sv =====
// Block-wise upload collector, top level: beat registers, handshake and state.
// Depends on coapb1_pkg, coapb1_cfg, coapb1_state and coapb1_eval.
//
// Each input beat is one received request's block option and payload length;
// each output beat is the answer: status, continue flag, DMA write window,
// body completion and the acknowledgement option. An accepted beat lands in an
// input register, is evaluated combinationally against the transfer state and is
// written to the output register, which drives out_valid and out_data; one beat
// is taken every cycle as long as the output side is not stalled. The output
// register decouples the sides: a new beat is taken while a finished result
// waits, and in_stall rises only while both registers are full and the output
// is stalled. Write configuration only while no beat is in flight; a
// capacity write reloads the body limit (saturated to BODY_CAPACITY_MAX) and a
// size write reloads the stored block size exponent. There is no memory and
// no clearing pass after reset.
module coap_block1_collector_unit #(
  parameter int unsigned BODY_CAPACITY_MAX = coapb1_pkg::BODY_CAPACITY_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  coapb1_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output coapb1_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  coapb1_pkg::cfg_idx_t              cfg_index,
  input  logic [coapb1_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                    in_v_r;
  coapb1_pkg::in_item_t    in_r;
  logic                    out_v_r;
  coapb1_pkg::out_item_t   out_r;
  logic                    adv;
  logic                    in_take;
  coapb1_pkg::out_item_t   res;
  coapb1_pkg::xfer_state_t st_cur;
  coapb1_pkg::xfer_state_t st_nxt;
  coapb1_pkg::cfg_load_t   cfg_load;

  // Advance the held beat when the output register is free or being drained
  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  coapb1_cfg #(
    .BODY_CAPACITY_MAX(BODY_CAPACITY_MAX)
  ) u_cfg (
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .load     (cfg_load)
  );

  coapb1_eval u_eval (
    .item(in_r),
    .cur (st_cur),
    .res (res),
    .nxt (st_nxt)
  );

  // Commit the state change together with the result beat
  coapb1_state #(
    .BODY_CAPACITY_MAX(BODY_CAPACITY_MAX)
  ) u_state (
    .clk  (clk),
    .rst_n(rst_n),
    .upd  (adv),
    .nxt  (st_nxt),
    .load (cfg_load),
    .cur  (st_cur)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== design/coapb1_checker.sv =====
// Port-level checks on the collector's result beats, bound to the top level.
// Depends on coapb1_pkg and coap_block1_collector_unit.
module coapb1_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input coapb1_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_wen_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_enable |->
      (out_data.status == coapb1_pkg::ST_OK) && !out_data.use_in_place)
    else $error("write window on a failed or in-place beat");

  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.body_done |->
      !out_data.want_more && (out_data.status == coapb1_pkg::ST_OK))
    else $error("body done while more blocks expected");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != coapb1_pkg::ST_OK) |->
      (out_data.ack_number == 20'd0) && (out_data.ack_szx == 3'd0)
      && !out_data.ack_more && !out_data.write_enable && !out_data.want_more)
    else $error("error beat carries acknowledgement or write");

endmodule

bind coap_block1_collector_unit coapb1_checker u_coapb1_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for coap_block1_collector_unit: directed requests, then random uploads,
// broken sequences and noise under random input gaps and output stalls.
// Depends on coapb1_pkg and the collector RTL.
module tb;

  // Generous bound: ~1650 beats, each waiting out sender gaps and heavy output stalls.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int          REPORT_MAX   = 200;

  // Tracks the transfer state the collector should hold and the answers it owes.
  class block1_tracker;
    coapb1_pkg::out_item_t answers_due[$];
    logic [2:0]  szx_setting;
    logic [31:0] coll_off;
    logic [31:0] limit;
    logic [19:0] number;
    logic        more;
    logic [2:0]  szx;
    int          errors;
    int          reports;
    int          tally[4];
    int          bodies;

    function new();
      szx_setting = coapb1_pkg::SZX_RESET;
      coll_off    = '0;
      limit       = coapb1_pkg::CAP_RESET;
      number      = '0;
      more        = 1'b0;
      szx         = coapb1_pkg::SZX_RESET;
      errors      = 0;
      reports     = 0;
      bodies      = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // A capacity write reloads the body limit, a size write the stored exponent.
    function void configure(coapb1_pkg::cfg_idx_t idx,
                            logic [coapb1_pkg::CFG_DATA_W-1:0] value);
      if (idx == coapb1_pkg::CFG_IDX_CAPACITY) begin
        limit = (value > coapb1_pkg::BODY_CAPACITY_MAX_DEF) ?
                coapb1_pkg::BODY_CAPACITY_MAX_DEF : value;
      end else begin
        szx_setting = value[2:0];
        szx         = value[2:0];
      end
    endfunction

    function coapb1_pkg::out_item_t block1_answer(coapb1_pkg::in_item_t rq);
      coapb1_pkg::out_item_t a;
      logic [31:0] len32;
      logic [31:0] bs;
      logic [31:0] boff;
      logic [31:0] total;
      logic        bad;
      a        = '0;
      a.status = coapb1_pkg::ST_OK;
      len32    = {16'd0, rq.payload_length};
      if (!rq.payload_present || !rq.option_present) begin
        // Whole body in one message, allowed only when nothing is collected
        if (coll_off != 0) begin
          a.status = coapb1_pkg::ST_BAD_MSG;
        end else begin
          number      = '0;
          more        = 1'b0;
          a.body_done = 1'b1;
          // Missing payload with a length counts as an empty body
          if (!(len32 > 0 && !rq.payload_present)) begin
            if (limit > 0) begin
              a.use_in_place = 1'b1;
              limit          = len32;
            end
            coll_off      = len32;
            a.body_length = len32;
          end
        end
      end else begin
        bs = (rq.size_exponent == coapb1_pkg::SZX_BERT) ? 32'd1024
                                                        : (32'd16 << rq.size_exponent);
        if (rq.size_exponent == coapb1_pkg::SZX_BERT)
          bad = rq.more_flag && (rq.payload_length[9:0] != 0);
        else
          bad = (rq.more_flag && len32 != bs) || len32 > bs;
        if (bad) begin
          a.status = coapb1_pkg::ST_BAD_MSG;
        end else begin
          boff = {12'd0, rq.blk_num} * bs;
          if (rq.blk_num == 0) coll_off = '0;
          if (coll_off != boff) begin
            a.status = coapb1_pkg::ST_UNEXP_BLOCK;
          end else if (coll_off != 0 && number == 0 && rq.size_exponent > szx) begin
            a.status = coapb1_pkg::ST_BAD_MSG;
          end else if (coll_off != 0 && number != 0 && rq.size_exponent != szx) begin
            a.status = coapb1_pkg::ST_BAD_MSG;
          end else begin
            // Second block may shrink the size; it sticks even if space runs out
            if (coll_off != 0 && number == 0) szx = rq.size_exponent;
            total = coll_off + len32;
            if (limit > 0) begin
              if (!rq.more_flag && coll_off == 0) begin
                a.use_in_place = 1'b1;
              end else if (total > limit) begin
                a.status = coapb1_pkg::ST_NO_SPACE;
              end else begin
                a.write_enable = 1'b1;
                a.write_offset = coll_off;
                a.write_length = rq.payload_length;
              end
              if (a.status == coapb1_pkg::ST_OK && !rq.more_flag) limit = total;
            end
            if (a.status == coapb1_pkg::ST_OK) begin
              coll_off     = total;
              number       = rq.blk_num;
              more         = rq.more_flag;
              a.want_more  = rq.more_flag;
              a.ack_number = rq.blk_num;
              a.ack_szx    = szx;
              a.ack_more   = rq.more_flag;
              if (!rq.more_flag) begin
                a.body_done   = 1'b1;
                a.body_length = total;
              end
            end
          end
        end
      end
      return a;
    endfunction

    function void take_request(coapb1_pkg::in_item_t rq);
      answers_due.push_back(block1_answer(rq));
    endfunction

    function bit same(string field, logic [31:0] expv, logic [31:0] actv);
      if (expv === actv) return 1'b1;
      // Keep the log short on a badly broken block
      if (reports < REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expv, actv);
      reports++;
      return 1'b0;
    endfunction

    function void match_answer(coapb1_pkg::out_item_t got);
      coapb1_pkg::out_item_t want;
      bit        ok;
      if (answers_due.size() == 0) begin
        $display("%0t: answer beat with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      ok = 1'b1;
      ok &= same("status", want.status, got.status);
      ok &= same("want_more", want.want_more, got.want_more);
      ok &= same("write_enable", want.write_enable, got.write_enable);
      ok &= same("write_offset", want.write_offset, got.write_offset);
      ok &= same("write_length", want.write_length, got.write_length);
      ok &= same("use_in_place", want.use_in_place, got.use_in_place);
      ok &= same("body_done", want.body_done, got.body_done);
      ok &= same("body_length", want.body_length, got.body_length);
      ok &= same("ack_number", want.ack_number, got.ack_number);
      ok &= same("ack_szx", want.ack_szx, got.ack_szx);
      ok &= same("ack_more", want.ack_more, got.ack_more);
      if (!ok) errors++;
      tally[want.status]++;
      if (want.body_done) bodies++;
    endfunction
  endclass

  // Every input starts at a known value
  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_stall;
  coapb1_pkg::in_item_t              in_data   = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  coapb1_pkg::out_item_t             out_data;
  logic                              cfg_we    = 1'b0;
  coapb1_pkg::cfg_idx_t              cfg_index = coapb1_pkg::CFG_IDX_CAPACITY;
  logic [coapb1_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  block1_tracker book;
  int unsigned   cycles     = 0;
  int unsigned   sent       = 0;
  int unsigned   burst_left = 0;
  int unsigned   settings   = 0;
  int unsigned   uploads    = 0;
  bit            steady     = 1'b0;

  coap_block1_collector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake or a missing answer ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sample the answer side at the edge; a beat moves when valid is high and stall is low
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.match_answer(out_data);
  end

  // Receiver: switch between stretches of no stall, light, medium and heavy stall
  initial begin : receiver
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  function automatic coapb1_pkg::in_item_t make_req(int unsigned opt, int unsigned num,
                                                    int unsigned more, int unsigned ex,
                                                    int unsigned pay, int unsigned len);
    coapb1_pkg::in_item_t rq;
    rq.option_present  = opt[0];
    rq.blk_num         = num[19:0];
    rq.more_flag       = more[0];
    rq.size_exponent   = ex[2:0];
    rq.payload_present = pay[0];
    rq.payload_length  = len[15:0];
    return rq;
  endfunction

  function automatic coapb1_pkg::in_item_t noise_request();
    coapb1_pkg::in_item_t rq;
    rq.option_present  = ($urandom_range(0, 3) != 0);
    rq.blk_num         = 20'($urandom_range(0, 1) ? $urandom_range(0, 8)
                                                  : $urandom_range(0, 20'hFFFFF));
    rq.more_flag       = 1'($urandom_range(0, 1));
    rq.size_exponent   = 3'($urandom_range(0, 7));
    rq.payload_present = ($urandom_range(0, 4) != 0);
    rq.payload_length  = 16'($urandom_range(0, 1) ? $urandom_range(0, 1100)
                                                  : $urandom_range(0, 16'hFFFF));
    return rq;
  endfunction

  // Break one aspect of an otherwise well-formed block
  function automatic coapb1_pkg::in_item_t damaged(coapb1_pkg::in_item_t rq);
    case ($urandom_range(0, 6))
      0:       rq.blk_num = rq.blk_num + 20'd1;
      1:       rq.payload_length = rq.payload_length ^ (16'd1 << $urandom_range(0, 15));
      2:       rq.size_exponent = 3'($urandom_range(0, 7));
      3:       rq.option_present = 1'b0;
      4:       rq.payload_present = 1'b0;
      5:       rq.more_flag = ~rq.more_flag;
      default: rq.blk_num = 20'($urandom_range(0, 20'hFFFFF));
    endcase
    return rq;
  endfunction

  // Drive one beat and hold it until accepted; open a gap between bursts
  task automatic send_request(coapb1_pkg::in_item_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    book.take_request(rq);
    sent++;
  endtask

  // Drop valid and hold off until every owed answer is back, then let the pipe settle
  task automatic idle_until_drained();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic reconfigure(bit do_cap, logic [coapb1_pkg::CFG_DATA_W-1:0] cap,
                             bit do_szx, logic [coapb1_pkg::CFG_DATA_W-1:0] szx_word);
    idle_until_drained();
    if (do_cap) begin
      cfg_we    <= 1'b1;
      cfg_index <= coapb1_pkg::CFG_IDX_CAPACITY;
      cfg_wdata <= cap;
      @(posedge clk);
      book.configure(coapb1_pkg::CFG_IDX_CAPACITY, cap);
    end
    if (do_szx) begin
      cfg_we    <= 1'b1;
      cfg_index <= coapb1_pkg::CFG_IDX_SZX;
      cfg_wdata <= szx_word;
      @(posedge clk);
      book.configure(coapb1_pkg::CFG_IDX_SZX, szx_word);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // One in-order upload with random content; the second block may shrink the size
  task automatic upload(int blocks);
    coapb1_pkg::in_item_t rq;
    logic [2:0]  ex;
    int unsigned off;
    int unsigned bs;
    int unsigned len;
    bit          closing;
    ex  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : book.szx;
    off = 0;
    uploads++;
    for (int i = 0; i < blocks; i++) begin
      closing = (i == blocks - 1);
      if (i == 1 && ex != 0 && $urandom_range(0, 5) == 0) ex = 3'($urandom_range(0, ex - 1));
      bs = (ex == coapb1_pkg::SZX_BERT) ? 1024 : (16 << ex);
      if (!closing)
        len = (ex == coapb1_pkg::SZX_BERT) ? 1024 * $urandom_range(1, 4) : bs;
      else
        len = $urandom_range(0, (ex == coapb1_pkg::SZX_BERT) ? 3000 : bs);
      rq = make_req(1, off / bs, !closing, ex, 1, len);
      if ($urandom_range(0, 11) == 0) rq = damaged(rq);
      send_request(rq);
      off += len;
    end
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned phase_end;
    int          pick;
    int          which;
    logic [coapb1_pkg::CFG_DATA_W-1:0] cap;
    book = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Capacity above the maximum saturates; size word with its low three bits set selects BERT
    reconfigure(1'b1, 13'h1FFF, 1'b1, 13'h1FFF);
    send_request(make_req(1, 0, 1, 7, 1, 1024));
    send_request(make_req(1, 1, 1, 7, 1, 2048));   // BERT block spans two numbers
    send_request(make_req(1, 3, 1, 7, 1, 3072));   // overruns the buffer
    send_request(make_req(1, 3, 1, 6, 1, 1024));   // size change after the second block
    send_request(make_req(1, 3, 0, 7, 1, 1000));   // last BERT block, any length
    send_request(make_req(0, 0, 0, 0, 1, 0));      // no option while collecting
    send_request(make_req(1, 0, 0, 0, 0, 7));      // payload missing while collecting
    send_request(make_req(1, 5, 0, 0, 1, 16));     // out of order
    send_request(make_req(1, 0, 1, 4, 1, 256));    // restart on block zero
    send_request(make_req(1, 1, 1, 4, 1, 256));    // second block shrinks the size
    send_request(make_req(1, 2, 1, 4, 1, 255));    // short block with more set
    send_request(make_req(1, 2, 0, 4, 1, 257));    // last block longer than the size
    send_request(make_req(1, 2, 0, 4, 1, 0));      // empty last block

    // Offsets only tracked, smallest block size
    reconfigure(1'b1, 13'd0, 1'b1, 13'd0);
    send_request(make_req(1, 0, 1, 7, 1, 0));              // empty BERT block clears offset
    send_request(make_req(0, 20'hFFFFF, 1, 7, 1, 16'hFFFF)); // whole body, longest length
    send_request(make_req(1, 0, 0, 0, 0, 0));
    send_request(make_req(1, 0, 1, 1, 1, 32));
    send_request(make_req(1, 1, 1, 1, 1, 32));             // second block tries to grow the size
    send_request(make_req(1, 20'hFFFFF, 1, 7, 1, 0));      // highest block number

    // Smallest useful buffer
    reconfigure(1'b1, 13'd16, 1'b1, 13'd3);
    send_request(make_req(1, 0, 1, 1, 1, 32));     // no space right after a restart
    send_request(make_req(1, 0, 1, 0, 0, 9));      // payload missing with a length: empty body
    send_request(make_req(1, 0, 0, 0, 1, 16));     // single block used in place
    send_request(make_req(1, 0, 1, 0, 1, 16));
    send_request(make_req(1, 1, 0, 0, 1, 1));      // shrink sticks although space runs out

    // Random phases, each under a fresh register setting
    base = sent;
    while (sent < base + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       cap = 13'd0;
        1:       cap = 13'd4096;
        2:       cap = 13'h1FFF;
        3:       cap = 13'd16;
        4, 5:    cap = 13'($urandom_range(0, 13'h1FFF));
        default: cap = 13'($urandom_range(1024, 4096));
      endcase
      which = $urandom_range(0, 4);
      reconfigure(which != 1, cap, which != 0,
                  {10'($urandom_range(0, 1023)), 3'($urandom_range(0, 7))});
      steady    = ($urandom_range(0, 3) == 0);
      phase_end = sent + $urandom_range(30, 70);
      while (sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 12)
          upload(($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6));
        else if (pick < 16)
          send_request(noise_request());
        else if (pick < 19)
          send_request(make_req(($urandom_range(0, 3) != 0) ? 0 : 1,
                                $urandom_range(0, 20'hFFFFF), $urandom_range(0, 1),
                                $urandom_range(0, 7), ($urandom_range(0, 3) != 0) ? 0 : 1,
                                $urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                     : $urandom_range(0, 16'hFFFF)));
        else
          idle_until_drained();
      end
    end

    idle_until_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests, %0d uploads, %0d register settings.",
             sent, uploads, settings);
    $display("Answers: %0d ok, %0d bad message, %0d out of order, %0d no space, %0d bodies.",
             book.tally[coapb1_pkg::ST_OK], book.tally[coapb1_pkg::ST_BAD_MSG],
             book.tally[coapb1_pkg::ST_UNEXP_BLOCK], book.tally[coapb1_pkg::ST_NO_SPACE],
             book.bodies);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== coap_block1_collector_unit.f =====
design/coapb1_pkg.sv
design/coapb1_cfg.sv
design/coapb1_state.sv
design/coapb1_eval.sv
design/coap_block1_collector_unit.sv
design/coapb1_checker.sv
tb/tb.sv
